// File: sv/tccs_pkg.sv
// Shared types and constants of the text console with cursor and scroll.
package tccs_pkg;

   localparam int CELL_W = 16;

   typedef logic [CELL_W-1:0] cell_type;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] COLOR_RESET  = 8'd7;
   localparam cell_type   RESET_CELL   = 16'h0720;

   typedef enum logic [1:0] {
      FUNC_PUT          = 2'd0,
      FUNC_CLEAR_SCREEN = 2'd1,
      FUNC_CLEAR_LINE   = 2'd2,
      FUNC_READ         = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL,
      ST_BLANK,
      ST_PUT,
      ST_RDWAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
   } rsp_type;

endpackage

// File: sv/text_console_cursor_scroll.sv
// Top level of the text console: cell store, cursor, scroll and clear sequencer.
//
// A ROWS x COLUMNS store of 16-bit cells (color in 15:8, character in 7:0) with a
// cursor. One request transfer is taken at a time; req_stall stays high until the
// request has been handed to the result register. A single address counter with
// its incrementer and end compare walks the store for every multi-cell operation,
// one cell per cycle through the single write port. Paths from request transfer
// to result register: put or newline without scroll, clear line while a scroll is
// pending, and an out-of-range read go straight to ST_DONE; an in-range read passes
// through ST_RDWAIT; clear line and clear screen pass through ST_BLANK; a put or
// newline that scrolls passes through ST_SCROLL and ST_BLANK, and a put then through
// ST_PUT. After reset the block fills the store with light grey spaces and holds
// req_stall high meanwhile; csr writes are taken at any time. A new request is
// taken while the previous result still waits in the result register.
module text_console_cursor_scroll
   import tccs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int COL_W  = $clog2(COLUMNS + 1);
   localparam int ADDR_W = $clog2(CELLS + 1);
   localparam int RAM_AW = $clog2(CELLS);

   localparam logic [ADDR_W-1:0] LastAddr   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] EndAddr    = ADDR_W'(CELLS);
   localparam logic [ADDR_W-1:0] RowStride  = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] ScrollBack = ADDR_W'(COLUMNS + 1);
   localparam logic [ADDR_W-1:0] BottomBase = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ROW_W-1:0]  RowsVal    = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0]  LastRow    = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  ColsVal    = COL_W'(COLUMNS);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] limit_ff, limit_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [7:0]        color_ff, color_in;
   logic [7:0]        char_ff, char_in;
   logic              put_pend_ff, put_pend_in;
   cell_type          data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   cell_type          ram_wdata;
   logic              ram_re;
   logic [RAM_AW-1:0] ram_raddr;
   cell_type          ram_rdata;

   // request decode
   logic              accept;
   logic              is_newline;
   logic              wrap;
   logic [ROW_W-1:0]  row_w;
   logic [COL_W-1:0]  col_w;
   logic              scroll_pending;
   logic              put_scrolls;
   logic              read_in_range;
   logic [ADDR_W-1:0] put_addr;
   logic [ADDR_W-1:0] line_base;
   logic [ADDR_W-1:0] read_addr;
   logic [ADDR_W-1:0] scroll_dst;
   logic              rsp_free;
   logic              rsp_load;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign is_newline = (req_data.char_code == NEWLINE_CODE);
   // a full row wraps to column zero of the next row before the put
   assign wrap       = (col_ff >= ColsVal);
   assign row_w      = wrap ? row_ff + ROW_W'(1) : row_ff;
   assign col_w      = wrap ? '0 : col_ff;
   assign scroll_pending = (row_ff >= RowsVal);
   assign put_scrolls    = is_newline ? scroll_pending : (row_w >= RowsVal);
   assign read_in_range  = (int'(req_data.read_row) < ROWS) &&
                           (int'(req_data.read_col) < COLUMNS);
   assign put_addr   = ADDR_W'(row_w) * RowStride + ADDR_W'(col_w);
   assign line_base  = ADDR_W'(row_ff) * RowStride;
   assign read_addr  = ADDR_W'(req_data.read_row) * RowStride + ADDR_W'(req_data.read_col);
   // during the copy the data in hand was read in the previous cycle, one row further down
   assign scroll_dst = addr_ff - ScrollBack;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == ST_DONE) && rsp_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (addr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_PUT:          state_in = put_scrolls ? ST_SCROLL : ST_DONE;
                  FUNC_CLEAR_SCREEN: state_in = ST_BLANK;
                  FUNC_CLEAR_LINE:   state_in = scroll_pending ? ST_DONE : ST_BLANK;
                  FUNC_READ:         state_in = read_in_range ? ST_RDWAIT : ST_DONE;
                  default:           state_in = ST_DONE;
               endcase
            end
         end
         ST_SCROLL: begin
            if (addr_ff == EndAddr) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            if (addr_ff == limit_ff) begin
               state_in = put_pend_ff ? ST_PUT : ST_DONE;
            end
         end
         ST_PUT:    state_in = ST_DONE;
         ST_RDWAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_INIT;
      endcase
   end

   // datapath and store control
   always_comb begin
      addr_in     = addr_ff;
      limit_in    = limit_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      char_in     = char_ff;
      put_pend_in = put_pend_ff;
      data_in     = data_ff;
      ram_we      = 1'b0;
      ram_waddr   = addr_ff[RAM_AW-1:0];
      ram_wdata   = {color_ff, SPACE_CODE};
      ram_re      = 1'b0;
      ram_raddr   = addr_ff[RAM_AW-1:0];
      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_CELL;
            addr_in   = addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               char_in     = req_data.char_code;
               data_in     = '0;
               put_pend_in = 1'b0;
               case (req_data.func)
                  FUNC_PUT: begin
                     if (is_newline) begin
                        col_in = '0;
                        if (scroll_pending) begin
                           // row stays at the pending mark
                           addr_in  = RowStride;
                           limit_in = LastAddr;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end else if (put_scrolls) begin
                        // scroll first, then put at the start of the bottom row
                        addr_in     = RowStride;
                        limit_in    = LastAddr;
                        put_pend_in = 1'b1;
                        row_in      = LastRow;
                        col_in      = COL_W'(1);
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = put_addr[RAM_AW-1:0];
                        ram_wdata = {color_ff, req_data.char_code};
                        row_in    = row_w;
                        col_in    = col_w + COL_W'(1);
                     end
                  end
                  FUNC_CLEAR_SCREEN: begin
                     addr_in  = '0;
                     limit_in = LastAddr;
                     col_in   = '0;
                  end
                  FUNC_CLEAR_LINE: begin
                     addr_in  = line_base;
                     limit_in = line_base + RowStride - ADDR_W'(1);
                     col_in   = '0;
                  end
                  FUNC_READ: begin
                     ram_re    = read_in_range;
                     ram_raddr = read_addr[RAM_AW-1:0];
                  end
                  default: begin
                     data_in = '0;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // read one row down, write the cell read in the cycle before
            ram_re    = (addr_ff != EndAddr);
            ram_we    = (addr_ff != RowStride);
            ram_waddr = scroll_dst[RAM_AW-1:0];
            ram_wdata = ram_rdata;
            if (addr_ff == EndAddr) begin
               addr_in  = BottomBase;
               limit_in = LastAddr;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         ST_BLANK: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
         end
         ST_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = BottomBase[RAM_AW-1:0];
            ram_wdata = {color_ff, char_ff};
         end
         ST_RDWAIT: begin
            data_in = ram_rdata;
         end
         ST_DONE: begin
            data_in = data_ff;
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   // configuration and result register
   always_comb begin
      color_in = color_ff;
      if (csr_valid) begin
         color_in = csr_data;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.cell_data  = data_ff;
         rsp_in.cursor_row = 5'(row_ff);
         rsp_in.cursor_col = 7'(col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         color_ff     <= COLOR_RESET;
         put_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         color_ff     <= color_in;
         put_pend_ff  <= put_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      char_ff  <= char_in;
      data_ff  <= data_in;
      rsp_ff   <= rsp_in;
   end

   tccs_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (RAM_AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// File: sv/tccs_ram.sv
// Cell store: one write port, one read port with registered read data.
module tccs_ram
   import tccs_pkg::*;
#(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  cell_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output cell_type          rd_data
);

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
